// File: rtl/civ_frequency_frame_parser_top_defines.svh
// Assertion macros for the frame parser.
// Each macro expands to a labelled concurrent assertion on clock, disabled
// during reset, or to nothing when SYNTHESIS is defined.
`ifndef CIV_FREQUENCY_FRAME_PARSER_TOP_DEFINES_SVH
`define CIV_FREQUENCY_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define CVFP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CVFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CVFP_ASSERT_SAME(lbl, ante, cons, msg)
`define CVFP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/cvfp_pkg.sv
`default_nettype none

package cvfp_pkg;

   // Frame geometry
   localparam int unsigned MAX_FRAME = 15;
   localparam int unsigned POS_W     = 4;
   localparam int unsigned HDR_LEN   = 5;
   localparam int unsigned HDR_IDX_W = 3;

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME - 1);
   localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(HDR_LEN);
   localparam logic [POS_W-1:0] MHZ_POS = POS_W'(8);
   localparam logic [POS_W-1:0] POS_STEP = POS_W'(1);

   // Header byte positions
   localparam logic [HDR_IDX_W-1:0] HDR_PRE0 = 3'd0;
   localparam logic [HDR_IDX_W-1:0] HDR_PRE1 = 3'd1;
   localparam logic [HDR_IDX_W-1:0] HDR_DEST = 3'd2;
   localparam logic [HDR_IDX_W-1:0] HDR_SRC  = 3'd3;
   localparam logic [HDR_IDX_W-1:0] HDR_CMD  = 3'd4;

   // Byte codes
   localparam logic [7:0] END_BYTE       = 8'hFD;
   localparam logic [7:0] PREAMBLE       = 8'hFE;
   localparam logic [7:0] BROADCAST_DEST = 8'h00;
   localparam logic [7:0] CMD_TRANSCEIVE = 8'h00;
   localparam logic [7:0] CMD_READ_FREQ  = 8'h03;

   // Register reset values
   localparam logic [7:0] RADIO_ADDR_RESET = 8'h94;
   localparam logic [7:0] CTRL_ADDR_RESET  = 8'hE0;

   // Register map
   localparam int unsigned CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIO_ADDR = 1'b0,
      CSR_CTRL_ADDR  = 1'b1
   } csr_index_type;

   typedef logic [HDR_LEN-1:0][7:0] hdr_bytes_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] mhz;
   } check_type;

   // High nibble times ten plus low nibble, by shifts and adds
   function automatic logic [7:0] bcd_to_mhz(input logic [7:0] value);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = {4'b0000, value[7:4]};
      lo = {4'b0000, value[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

endpackage

`default_nettype wire

// File: rtl/cvfp_frame_check.sv
`default_nettype none

module cvfp_frame_check (
   input  wire cvfp_pkg::hdr_bytes_type hdr,
   input  wire logic [7:0]              freq_byte,
   input  wire logic [7:0]              radio_address,
   input  wire logic [7:0]              controller_address,
   output cvfp_pkg::check_type          check
);

   logic preamble_ok;
   logic source_ok;
   logic broadcast;
   logic reply;

   // Match preambles and source address
   assign preamble_ok = (hdr[cvfp_pkg::HDR_PRE0] == cvfp_pkg::PREAMBLE) &&
                        (hdr[cvfp_pkg::HDR_PRE1] == cvfp_pkg::PREAMBLE);
   assign source_ok   = (hdr[cvfp_pkg::HDR_SRC] == radio_address);

   // Accept a broadcast transceive frame or a reply to this controller
   assign broadcast = (hdr[cvfp_pkg::HDR_DEST] == cvfp_pkg::BROADCAST_DEST) &&
                      (hdr[cvfp_pkg::HDR_CMD] == cvfp_pkg::CMD_TRANSCEIVE);
   assign reply     = (hdr[cvfp_pkg::HDR_DEST] == controller_address) &&
                      (hdr[cvfp_pkg::HDR_CMD] == cvfp_pkg::CMD_READ_FREQ);

   // Combine the checks and decode the MHz byte
   always_comb begin
      check.ok  = preamble_ok && source_ok && (broadcast || reply);
      check.mhz = cvfp_pkg::bcd_to_mhz(freq_byte);
   end

endmodule

`default_nettype wire

// File: rtl/civ_frequency_frame_parser_top.sv
`default_nettype none

`include "civ_frequency_frame_parser_top_defines.svh"

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_rx_byte
// rsp      out        rsp_valid/rsp_stall  rsp_frame_ok, rsp_mhz, rsp_changed
// csr      in         csr_wr_en            csr_index, csr_wr_data
//
// One byte is taken per cycle while req is not stalled; its frame store update and,
// on an end byte, the header check and MHz decode complete in that cycle.
// A result appears on rsp in the cycle after its end byte is accepted.
// req stalls only while a result is held in the output register and rsp stalls.
// Synchronous reset clears position, stored header, MHz byte and last value,
// and restores both address registers.
module civ_frequency_frame_parser_top (
   input  wire  logic                             clock,
   input  wire  logic                             reset,
   input  wire  logic                             req_valid,
   output logic                                   req_stall,
   input  wire  logic [7:0]                       req_rx_byte,
   output logic                                   rsp_valid,
   input  wire  logic                             rsp_stall,
   output logic                                   rsp_frame_ok,
   output logic [7:0]                             rsp_mhz,
   output logic                                   rsp_changed,
   input  wire  logic                             csr_wr_en,
   input  wire  logic [cvfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  logic [7:0]                       csr_wr_data
);

   logic [7:0]                  radio_addr_ff;
   logic [7:0]                  ctrl_addr_ff;
   logic [cvfp_pkg::POS_W-1:0]  pos_ff;
   logic [cvfp_pkg::POS_W-1:0]  pos_in;
   cvfp_pkg::hdr_bytes_type     hdr_ff;
   cvfp_pkg::hdr_bytes_type     hdr_in;
   logic [7:0]                  freq_ff;
   logic [7:0]                  freq_in;
   logic [7:0]                  last_mhz_ff;
   logic                        have_last_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_frame_ok_ff;
   logic [7:0]                  rsp_mhz_ff;
   logic                        rsp_changed_ff;
   logic                        accept;
   logic                        is_end;
   logic                        rsp_load;
   logic                        changed;
   cvfp_pkg::check_type         check;

   // Handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign is_end    = (req_rx_byte == cvfp_pkg::END_BYTE);
   assign rsp_load  = accept && is_end;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radio_addr_ff <= cvfp_pkg::RADIO_ADDR_RESET;
         ctrl_addr_ff  <= cvfp_pkg::CTRL_ADDR_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            cvfp_pkg::CSR_RADIO_ADDR: radio_addr_ff <= csr_wr_data;
            cvfp_pkg::CSR_CTRL_ADDR:  ctrl_addr_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Store a header or MHz byte at its position; advance, hold at the last position, or restart
   always_comb begin
      hdr_in  = hdr_ff;
      freq_in = freq_ff;
      if (pos_ff < cvfp_pkg::POS_HDR_END) begin
         hdr_in[pos_ff[cvfp_pkg::HDR_IDX_W-1:0]] = req_rx_byte;
      end
      if (pos_ff == cvfp_pkg::MHZ_POS) begin
         freq_in = req_rx_byte;
      end
      if (is_end) begin
         pos_in = '0;
      end else if (pos_ff != cvfp_pkg::POS_LAST) begin
         pos_in = pos_ff + cvfp_pkg::POS_STEP;
      end else begin
         pos_in = pos_ff;
      end
   end

   // Check the frame as it stands with this byte included
   cvfp_frame_check u_check (
      .hdr                (hdr_in),
      .freq_byte          (freq_in),
      .radio_address      (radio_addr_ff),
      .controller_address (ctrl_addr_ff),
      .check              (check)
   );

   assign changed = check.ok && (!have_last_ff || (check.mhz != last_mhz_ff));

   // Frame store and last decoded value
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hdr_ff       <= '0;
         freq_ff      <= '0;
         last_mhz_ff  <= '0;
         have_last_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         hdr_ff  <= hdr_in;
         freq_ff <= freq_in;
         if (is_end && changed) begin
            last_mhz_ff  <= check.mhz;
            have_last_ff <= 1'b1;
         end
      end
   end

   // Output register: load on an end byte, hold while stalled
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_frame_ok_ff <= check.ok;
         rsp_mhz_ff      <= check.ok ? check.mhz : 8'h00;
         rsp_changed_ff  <= changed;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_frame_ok = rsp_frame_ok_ff;
   assign rsp_mhz      = rsp_mhz_ff;
   assign rsp_changed  = rsp_changed_ff;

   // Checks
   `CVFP_ASSERT_NEXT(a_end_gives_result, rsp_load, rsp_valid_ff && (pos_ff == '0),
                     "end byte without result or restart")
   `CVFP_ASSERT_NEXT(a_pos_advance,
                     accept && !is_end && (pos_ff != cvfp_pkg::POS_LAST),
                     pos_ff == $past(pos_ff) + cvfp_pkg::POS_STEP,
                     "position did not advance")
   `CVFP_ASSERT_SAME(a_changed_tracks_last, rsp_valid_ff && rsp_changed_ff,
                     rsp_frame_ok_ff && have_last_ff && (last_mhz_ff == rsp_mhz_ff),
                     "changed result disagrees with last value")

endmodule

`default_nettype wire
